FILE: rtl/wvm_pkg.sv
// Shared types, constants and opcode codes for the word machine core.
// Used by wvm_ctrl, wvm_dp and word_vm_instruction_core; no dependencies.
`default_nettype none
package wvm_pkg;

  // Memory depth must be a power of two so that addresses wrap by truncation.
  localparam int MEM_WORDS   = 32768;
  localparam int STACK_DEPTH = 4096;
  localparam int AW          = $clog2(MEM_WORDS);
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int SPW         = SAW + 1;
  localparam int MOD_STEPS   = 16;
  localparam int MCW         = $clog2(MOD_STEPS) + 1;

  localparam logic [15:0] LIT_MASK  = 16'h7fff;
  localparam logic [15:0] REG_BASE  = 16'h8000;
  localparam logic [7:0]  OPC_MASK  = 8'hff;

  localparam logic [2:0] ST_EXEC  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_HALT  = 3'd2;
  localparam logic [2:0] ST_FAULT = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_SET  = 8'd1;
  localparam logic [7:0] OP_PUSH = 8'd2;
  localparam logic [7:0] OP_POP  = 8'd3;
  localparam logic [7:0] OP_EQ   = 8'd4;
  localparam logic [7:0] OP_GT   = 8'd5;
  localparam logic [7:0] OP_JMP  = 8'd6;
  localparam logic [7:0] OP_JT   = 8'd7;
  localparam logic [7:0] OP_JF   = 8'd8;
  localparam logic [7:0] OP_ADD  = 8'd9;
  localparam logic [7:0] OP_MULT = 8'd10;
  localparam logic [7:0] OP_MOD  = 8'd11;
  localparam logic [7:0] OP_AND  = 8'd12;
  localparam logic [7:0] OP_OR   = 8'd13;
  localparam logic [7:0] OP_NOT  = 8'd14;
  localparam logic [7:0] OP_RMEM = 8'd15;
  localparam logic [7:0] OP_WMEM = 8'd16;
  localparam logic [7:0] OP_CALL = 8'd17;
  localparam logic [7:0] OP_RET  = 8'd18;
  localparam logic [7:0] OP_OUT  = 8'd19;
  localparam logic [7:0] OP_IN   = 8'd20;
  localparam logic [7:0] OP_NOOP = 8'd21;

  typedef enum logic [1:0] {
    RS_RUN   = 2'd0,
    RS_WAIT  = 2'd1,
    RS_HALT  = 2'd2,
    RS_FAULT = 2'd3
  } run_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_F0, CS_F1, CS_F2, CS_F3, CS_RESOLVE, CS_DECIDE,
    CS_RMEM, CS_STK, CS_MOD, CS_COMMIT
  } cstate_t;

  typedef enum logic {
    RD_PC = 1'b0,
    RD_B  = 1'b1
  } rdsel_t;

  typedef struct packed {
    logic       accept;
    logic       load_wr;
    logic       mem_rd;
    rdsel_t     rd_sel;
    logic [1:0] rd_off;
    logic       cap_en;
    logic [1:0] cap_idx;
    logic       resolve;
    logic       stk_rd;
    logic       mod_start;
    logic       mod_step;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic need_rmem;
    logic need_stk;
    logic need_mod;
    logic mod_done;
  } sts_t;

  function automatic logic is_lit(input logic [15:0] w);
    return ~w[15];
  endfunction

  function automatic logic is_reg(input logic [15:0] w);
    return w[15:3] == REG_BASE[15:3];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/wvm_ctrl.sv
// Sequencer for the word machine: fetch, operand resolve, optional memory,
// stack or modulo step, then commit into the result register. Uses wvm_pkg.
`default_nettype none
module wvm_ctrl
  import wvm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic      item_stall,
  input  wire logic kind,
  output logic      result_valid,
  input  wire logic result_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  cstate_t state, state_next;
  logic    out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rd_sel    = RD_PC;
    out_full_next = out_full && result_stall;
    unique case (state)
      CS_IDLE: begin
        if (item_valid) begin
          cmd.accept  = 1'b1;
          cmd.load_wr = ~kind;
          state_next  = (!kind || sts.stopped) ? CS_COMMIT : CS_F0;
        end
      end
      CS_F0: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_off = 2'd0;
        state_next = CS_F1;
      end
      CS_F1: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd0;
        cmd.mem_rd  = 1'b1;
        cmd.rd_off  = 2'd1;
        state_next  = CS_F2;
      end
      CS_F2: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd1;
        cmd.mem_rd  = 1'b1;
        cmd.rd_off  = 2'd2;
        state_next  = CS_F3;
      end
      CS_F3: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd2;
        cmd.mem_rd  = 1'b1;
        cmd.rd_off  = 2'd3;
        state_next  = CS_RESOLVE;
      end
      CS_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = CS_DECIDE;
      end
      CS_DECIDE: begin
        priority if (sts.need_rmem) begin
          state_next = CS_RMEM;
        end else if (sts.need_stk) begin
          state_next = CS_STK;
        end else if (sts.need_mod) begin
          cmd.mod_start = 1'b1;
          state_next    = CS_MOD;
        end else begin
          state_next = CS_COMMIT;
        end
      end
      CS_RMEM: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_B;
        state_next = CS_COMMIT;
      end
      CS_STK: begin
        cmd.stk_rd = 1'b1;
        state_next = CS_COMMIT;
      end
      CS_MOD: begin
        if (sts.mod_done) begin
          state_next = CS_COMMIT;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      CS_COMMIT: begin
        // The result register must be empty or emptying this cycle.
        if (!out_full || !result_stall) begin
          cmd.commit    = 1'b1;
          out_full_next = 1'b1;
          state_next    = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  assign item_stall   = (state != CS_IDLE);
  assign result_valid = out_full;

endmodule
`default_nettype wire

FILE: rtl/wvm_dp.sv
// Datapath of the word machine: main memory, return stack, register file,
// pc, operand resolve, modulo unit and the result register. Uses wvm_pkg.
`default_nettype none
module wvm_dp
  import wvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        kind,
  input  wire logic [14:0] load_addr,
  input  wire logic [15:0] load_data,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_valid,
  output logic [2:0]       status,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             input_used,
  output logic [14:0]      next_pc
);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] stk [STACK_DEPTH];
  logic [15:0] regs [8];
  logic [15:0] rdata, stk_q;
  logic [AW-1:0]  pc, rd_addr;
  logic [SPW-1:0] sp;
  run_t        run;

  logic        kind_q, ivalid_q;
  logic [7:0]  ichar_q;
  logic [7:0]  op;
  logic [15:0] w1, w2;
  logic [15:0] av, bv, cv;
  logic        aok, bok, cok, rok;
  logic [2:0]  rdst;

  logic [15:0]    rem, dvd;
  logic [MCW-1:0] mcnt;
  logic [16:0]    rem_sh;

  logic        stopped, sp_zero, sp_full;
  logic        c_ok, c_wr, c_push, c_pop, c_wmem, c_ov, c_used, eff;
  logic [15:0] c_res, c_push_val;
  logic [2:0]  c_status;
  logic [7:0]  c_oc;
  logic [AW-1:0] c_npc;
  logic [31:0] prod;

  assign stopped = (run == RS_HALT) || (run == RS_FAULT);
  assign sp_zero = (sp == '0);
  assign sp_full = (sp >= SPW'(STACK_DEPTH));

  // Memory with one write and one registered read port.
  assign rd_addr = (cmd.rd_sel == RD_B) ? bv[AW-1:0] : pc + AW'(cmd.rd_off);

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[load_addr[AW-1:0]] <= load_data;
    end else if (cmd.commit && eff && c_wmem) begin
      mem[av[AW-1:0]] <= bv;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && eff && c_push) begin
      stk[sp[SAW-1:0]] <= c_push_val;
    end
    if (cmd.stk_rd) begin
      stk_q <= stk[SAW'(sp - SPW'(1))];
    end
  end

  // Input latch, fetched words and resolved operands.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= kind;
      ichar_q  <= in_char;
      ivalid_q <= in_valid;
    end
    if (cmd.cap_en) begin
      unique case (cmd.cap_idx)
        2'd0:    op <= rdata[7:0] & OPC_MASK;
        2'd1:    w1 <= rdata;
        default: w2 <= rdata;
      endcase
    end
    if (cmd.resolve) begin
      av   <= is_lit(w1) ? w1 : regs[w1[2:0]];
      bv   <= is_lit(w2) ? w2 : regs[w2[2:0]];
      cv   <= is_lit(rdata) ? rdata : regs[rdata[2:0]];
      aok  <= is_lit(w1) | is_reg(w1);
      bok  <= is_lit(w2) | is_reg(w2);
      cok  <= is_lit(rdata) | is_reg(rdata);
      rok  <= is_reg(w1);
      rdst <= w1[2:0];
    end
  end

  // Restoring remainder, one quotient bit per cycle.
  assign rem_sh = {rem, dvd[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mod_start) begin
      mcnt <= MCW'(MOD_STEPS);
    end else if (cmd.mod_step) begin
      mcnt <= mcnt - MCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      rem <= '0;
      dvd <= bv;
    end else if (cmd.mod_step) begin
      rem <= (rem_sh >= {1'b0, cv}) ? 16'(rem_sh - {1'b0, cv}) : rem_sh[15:0];
      dvd <= {dvd[14:0], 1'b0};
    end
  end

  assign sts.stopped   = stopped;
  assign sts.need_rmem = (op == OP_RMEM) && rok && bok;
  assign sts.need_stk  = ((op == OP_POP) && rok && !sp_zero) || ((op == OP_RET) && !sp_zero);
  assign sts.need_mod  = (op == OP_MOD) && rok && bok && cok && (cv != '0);
  assign sts.mod_done  = (mcnt == '0);

  assign prod = bv * cv;

  always_comb begin
    c_ok       = 1'b1;
    c_wr       = 1'b0;
    c_res      = '0;
    c_status   = ST_EXEC;
    c_ov       = 1'b0;
    c_oc       = '0;
    c_used     = 1'b0;
    c_npc      = pc;
    c_push     = 1'b0;
    c_push_val = '0;
    c_pop      = 1'b0;
    c_wmem     = 1'b0;
    unique case (op)
      OP_HALT: c_status = ST_HALT;
      OP_SET: begin
        c_ok = rok && bok; c_res = bv; c_wr = 1'b1; c_npc = pc + AW'(3);
      end
      OP_RMEM: begin
        c_ok = rok && bok; c_res = rdata; c_wr = 1'b1; c_npc = pc + AW'(3);
      end
      OP_POP: begin
        c_ok = rok && !sp_zero; c_res = stk_q; c_wr = 1'b1; c_pop = 1'b1;
        c_npc = pc + AW'(2);
      end
      OP_IN: begin
        c_ok = rok;
        if (ivalid_q) begin
          c_res = {8'd0, ichar_q}; c_wr = 1'b1; c_used = 1'b1; c_npc = pc + AW'(2);
        end else begin
          c_status = ST_WAIT;
        end
      end
      OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: begin
        c_ok  = rok && bok && cok && ((op != OP_MOD) || (cv != '0));
        c_wr  = 1'b1;
        c_npc = pc + AW'(4);
        unique case (op)
          OP_EQ:   c_res = {15'd0, bv == cv};
          OP_GT:   c_res = {15'd0, bv > cv};
          OP_ADD:  c_res = 16'(bv + cv) & LIT_MASK;
          OP_MULT: c_res = prod[15:0] & LIT_MASK;
          OP_MOD:  c_res = rem;
          OP_AND:  c_res = bv & cv;
          default: c_res = bv | cv;
        endcase
      end
      OP_NOT: begin
        c_ok = rok && bok; c_res = ~bv & LIT_MASK; c_wr = 1'b1; c_npc = pc + AW'(3);
      end
      OP_PUSH: begin
        c_ok = aok && !sp_full; c_push = 1'b1; c_push_val = av; c_npc = pc + AW'(2);
      end
      OP_CALL: begin
        c_ok = aok && !sp_full; c_push = 1'b1;
        c_push_val = 16'(pc + AW'(2)); c_npc = av[AW-1:0];
      end
      OP_JMP: begin
        c_ok = aok; c_npc = av[AW-1:0];
      end
      OP_JT, OP_JF: begin
        c_ok  = aok && bok;
        c_npc = ((av != '0) == (op == OP_JT)) ? bv[AW-1:0] : pc + AW'(3);
      end
      OP_WMEM: begin
        c_ok = aok && bok; c_wmem = 1'b1; c_npc = pc + AW'(3);
      end
      OP_RET: begin
        if (sp_zero) begin
          c_status = ST_HALT;
        end else begin
          c_pop = 1'b1; c_npc = stk_q[AW-1:0];
        end
      end
      OP_OUT: begin
        c_ok = aok; c_ov = 1'b1; c_oc = av[7:0]; c_npc = pc + AW'(2);
      end
      OP_NOOP: c_npc = pc + AW'(1);
      default: c_ok = 1'b0;
    endcase
    if (!c_ok) begin
      c_status = ST_FAULT; c_npc = pc; c_ov = 1'b0; c_oc = '0; c_used = 1'b0;
    end
  end

  assign eff = kind_q && !stopped && c_ok;

  // Architectural state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      sp  <= '0;
      run <= RS_RUN;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else if (cmd.commit && kind_q && !stopped) begin
      pc  <= c_npc;
      run <= run_t'(c_status[1:0]);
      if (eff && c_wr) regs[rdst] <= c_res;
      if (eff && c_push) sp <= sp + SPW'(1);
      else if (eff && c_pop) sp <= sp - SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!kind_q) begin
        status <= ST_LOAD; out_valid <= 1'b0; out_char <= '0; input_used <= 1'b0;
        next_pc <= 15'(pc);
      end else if (stopped) begin
        status <= {1'b0, run}; out_valid <= 1'b0; out_char <= '0; input_used <= 1'b0;
        next_pc <= 15'(pc);
      end else begin
        status <= c_status; out_valid <= c_ov; out_char <= c_oc; input_used <= c_used;
        next_pc <= 15'(c_npc);
      end
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_fault_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && kind_q && !stopped && !c_ok |=> pc == $past(pc))
    else $error("faulting instruction moved the pc");

  a_stopped_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("left halt or fault without reset");

  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> cv != '0)
    else $error("modulo started with a zero divisor");

endmodule
`default_nettype wire

FILE: rtl/word_vm_instruction_core.sv
// A load word is accepted in the idle state, which writes memory, and its result
// is registered in the commit state. An execute word on a running machine passes
// through the accepting state, four fetch states that read opcode and operands
// from memory, a resolve and a decide state, and a commit. RMEM and POP/RET add
// a state for their memory or stack read, and MOD adds the steps of its bit-serial
// remainder unit. The single memory port sets this sequence. A new word is taken
// while the previous result still waits, but its commit then holds until that
// result has been taken.
// Top level; instantiates wvm_ctrl and wvm_dp and uses wvm_pkg.
`default_nettype none
module word_vm_instruction_core
  import wvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        kind,
  input  wire logic [14:0] load_addr,
  input  wire logic [15:0] load_data,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_valid,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       status,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             input_used,
  output logic [14:0]      next_pc
);

  cmd_t cmd;
  sts_t sts;

  wvm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  wvm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .load_addr  (load_addr),
    .load_data  (load_data),
    .in_char    (in_char),
    .in_valid   (in_valid),
    .status     (status),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .input_used (input_used),
    .next_pc    (next_pc)
  );

endmodule
`default_nettype wire
